### rtl/core/bpfs_pkg.sv
package bpfs_pkg;

  localparam int unsigned COUNT_W    = 14;
  localparam int unsigned TEMP_W     = 11;
  localparam int unsigned PRESS_W    = 21;
  localparam int unsigned OUT_PRESS_W = 32;
  localparam int unsigned OUT_TEMP_W = 15;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // Magnitude of the pressure product needs 35 bits; one quotient bit per step.
  localparam int unsigned DIV_STEPS  = 35;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] OUT_MIN_RST   = 14'd1638;
  localparam logic [COUNT_W-1:0] OUT_MAX_RST   = 14'd14745;
  localparam logic [PRESS_W-1:0] PRESS_MIN_RST = 21'd0;
  localparam logic [PRESS_W-1:0] PRESS_MAX_RST = 21'd1000000;

  // count * 20000 / 2047 by reciprocal: ceil(2^37 / 2047), exact for inputs below 2^26
  localparam logic [25:0] TEMP_SCALE  = 26'd20000;
  localparam logic [26:0] TEMP_RECIP  = 27'd67141649;
  localparam int unsigned TEMP_SHIFT  = 37;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd5000;

  localparam logic [1:0] FRAME_OK    = 2'd0;
  localparam logic [1:0] FRAME_STALE = 2'd2;

  typedef enum logic [1:0] {
    REG_OUT_MIN   = 2'd0,
    REG_OUT_MAX   = 2'd1,
    REG_PRESS_MIN = 2'd2,
    REG_PRESS_MAX = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] out_min;
    logic [COUNT_W-1:0] out_max;
    logic [PRESS_W-1:0] press_min;
    logic [PRESS_W-1:0] press_max;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic prep;
    logic div_step;
    logic fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_scale;
    logic den_zero;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/core/bpfs_if.sv
interface bpfs_in_if;
  import bpfs_pkg::*;

  logic        valid;
  logic        ready;
  logic        func;
  logic        read_ok;
  logic [31:0] frame_word;

  modport source (output valid, func, read_ok, frame_word, input ready);
  modport sink   (input valid, func, read_ok, frame_word, output ready);
endinterface

interface bpfs_out_if;
  import bpfs_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          read_accepted;
  logic                          sample_valid;
  logic signed [OUT_PRESS_W-1:0] pressure_value;
  logic signed [OUT_TEMP_W-1:0]  temperature_centi;

  modport source (output valid, read_accepted, sample_valid, pressure_value,
                  temperature_centi, input ready);
  modport sink   (input valid, read_accepted, sample_valid, pressure_value,
                  temperature_centi, output ready);
endinterface

### rtl/core/bpfs_regs.sv
module bpfs_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpfs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bpfs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bpfs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output bpfs_pkg::cfg_t                      cfg
);
  import bpfs_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_min   <= OUT_MIN_RST;
      cfg_r.out_max   <= OUT_MAX_RST;
      cfg_r.press_min <= PRESS_MIN_RST;
      cfg_r.press_max <= PRESS_MAX_RST;
    end else if (wr_en) begin
      case (idx)
        REG_OUT_MIN:   cfg_r.out_min   <= pwdata[COUNT_W-1:0];
        REG_OUT_MAX:   cfg_r.out_max   <= pwdata[COUNT_W-1:0];
        REG_PRESS_MIN: cfg_r.press_min <= pwdata[PRESS_W-1:0];
        REG_PRESS_MAX: cfg_r.press_max <= pwdata[PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OUT_MIN:   prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, cfg_r.out_min};
      REG_OUT_MAX:   prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, cfg_r.out_max};
      REG_PRESS_MIN: prdata = {{(APB_DATA_W-PRESS_W){cfg_r.press_min[PRESS_W-1]}},
                               cfg_r.press_min};
      REG_PRESS_MAX: prdata = {{(APB_DATA_W-PRESS_W){cfg_r.press_max[PRESS_W-1]}},
                               cfg_r.press_max};
      default:       prdata = '0;
    endcase
  end

endmodule

### rtl/core/bpfs_ctrl.sv
module bpfs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bpfs_pkg::dp_status_t   status,
  output bpfs_pkg::cmd_t         cmd
);
  import bpfs_pkg::*;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 last_step;

  assign last_step = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.need_scale ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL:  state_nxt = ST_PREP;
      ST_PREP: begin
        cnt_nxt   = '0;
        state_nxt = status.den_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_MUL:  cmd.mul      = 1'b1;
      ST_PREP: cmd.prep     = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FIN:  cmd.fin      = 1'b1;
      ST_OUT:  cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/core/bpfs_dp.sv
module bpfs_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bpfs_pkg::cfg_t                         cfg,
  input  bpfs_pkg::cmd_t                         cmd,
  output bpfs_pkg::dp_status_t                   status,
  input  logic                                   in_func,
  input  logic                                   in_read_ok,
  input  logic [31:0]                            in_frame_word,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_read_accepted,
  output logic                                   out_sample_valid,
  output logic signed [bpfs_pkg::OUT_PRESS_W-1:0] out_pressure_value,
  output logic signed [bpfs_pkg::OUT_TEMP_W-1:0]  out_temperature_centi
);
  import bpfs_pkg::*;

  // sensor state
  logic [COUNT_W-1:0] bridge_r;
  logic [TEMP_W-1:0]  temp_r;
  logic               fresh_r;

  // frame decode
  logic [1:0]         fr_status;
  logic [COUNT_W-1:0] fr_bridge;
  logic [TEMP_W-1:0]  fr_temp;
  logic               frame_good, do_read, took, fresh_after, need_scale;

  assign fr_status = in_frame_word[31:30];
  assign fr_bridge = in_frame_word[29:16];
  assign fr_temp   = in_frame_word[15:5];

  assign frame_good = in_read_ok &&
                      ((fr_status == FRAME_OK) ||
                       ((fr_status == FRAME_STALE) &&
                        ((fr_bridge != bridge_r) || (fr_temp != temp_r))));
  assign do_read     = !in_func || !fresh_r;
  assign took        = do_read && frame_good;
  assign fresh_after = fresh_r || took;
  assign need_scale  = in_func && fresh_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bridge_r <= '0;
      temp_r   <= '0;
      fresh_r  <= 1'b0;
    end else if (cmd.accept) begin
      if (took) begin
        bridge_r <= fr_bridge;
        temp_r   <= fr_temp;
      end
      fresh_r <= need_scale ? 1'b0 : fresh_after;
    end
  end

  // scaling arithmetic
  logic signed [COUNT_W:0]   diff, den;
  logic signed [PRESS_W:0]   span;
  logic signed [36:0]        prod_full;
  logic signed [35:0]        prod_r, prod_neg;
  logic [25:0]               tx_r;
  logic [52:0]               tprod;
  logic signed [15:0]        tc;
  logic [34:0]               prod_mag;
  logic [COUNT_W:0]          den_neg;
  logic [COUNT_W-1:0]        den_mag;
  logic                      den_zero;

  assign diff = $signed({1'b0, bridge_r}) - $signed({1'b0, cfg.out_min});
  assign den  = $signed({1'b0, cfg.out_max}) - $signed({1'b0, cfg.out_min});
  assign span = $signed({cfg.press_max[PRESS_W-1], cfg.press_max}) -
                $signed({cfg.press_min[PRESS_W-1], cfg.press_min});
  assign prod_full = 37'(diff) * 37'(span);
  assign den_zero  = (cfg.out_max == cfg.out_min);

  assign prod_neg = -prod_r;
  assign prod_mag = prod_r[35] ? prod_neg[34:0] : prod_r[34:0];
  assign den_neg  = -den;
  assign den_mag  = den[COUNT_W] ? den_neg[COUNT_W-1:0] : den[COUNT_W-1:0];

  assign tprod = {27'd0, tx_r} * {26'd0, TEMP_RECIP};
  assign tc    = $signed(tprod[TEMP_SHIFT+15:TEMP_SHIFT]) - TEMP_OFFSET;

  // serial restoring divider on magnitudes
  logic [COUNT_W-1:0] rem_r, dsor_r;
  logic [34:0]        quo_r;
  logic               neg_r;
  logic [COUNT_W:0]   shifted, trial;
  logic               fits;

  assign shifted = {rem_r, quo_r[34]};
  assign trial   = shifted - {1'b0, dsor_r};
  assign fits    = (shifted >= {1'b0, dsor_r});

  // result assembly
  logic signed [36:0]        quo_s;
  logic signed [37:0]        sum;
  logic [6:0]                sum_hi;
  logic signed [OUT_PRESS_W-1:0] press_sat;
  logic signed [OUT_TEMP_W-1:0]  tempc_r;

  always_comb begin
    if (den_zero) begin
      quo_s = {prod_r[35], prod_r};
    end else if (neg_r) begin
      quo_s = -$signed({2'b00, quo_r});
    end else begin
      quo_s = $signed({2'b00, quo_r});
    end
    sum    = {quo_s[36], quo_s} +
             $signed({{(38-PRESS_W){cfg.press_min[PRESS_W-1]}}, cfg.press_min});
    sum_hi = sum[37:31];
    if (sum_hi == 7'h00 || sum_hi == 7'h7f) begin
      press_sat = sum[31:0];
    end else if (sum[37]) begin
      press_sat = {1'b1, {(OUT_PRESS_W-1){1'b0}}};
    end else begin
      press_sat = {1'b0, {(OUT_PRESS_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_full[35:0];
      tx_r   <= {15'd0, temp_r} * TEMP_SCALE;
    end
    if (cmd.prep) begin
      quo_r   <= prod_mag;
      rem_r   <= '0;
      dsor_r  <= den_mag;
      neg_r   <= prod_r[35] ^ den[COUNT_W];
      tempc_r <= tc[OUT_TEMP_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quo_r <= {quo_r[33:0], fits};
    end
  end

  // per-transaction result, then output register
  logic                          res_acc_r, res_valid_r;
  logic signed [OUT_PRESS_W-1:0] res_press_r;
  logic signed [OUT_TEMP_W-1:0]  res_temp_r;
  logic                          out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_acc_r   <= took;
      res_valid_r <= 1'b0;
      res_press_r <= '0;
      res_temp_r  <= '0;
    end else if (cmd.fin) begin
      res_valid_r <= 1'b1;
      res_press_r <= press_sat;
      res_temp_r  <= tempc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_accepted     <= res_acc_r;
      out_sample_valid      <= res_valid_r;
      out_pressure_value    <= res_press_r;
      out_temperature_centi <= res_temp_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign status.need_scale = need_scale;
  assign status.den_zero   = den_zero;
  assign status.out_free   = !out_valid_r || out_ready;

endmodule

### rtl/core/bridge_pressure_frame_scaler_unit.sv
// Bridge pressure frame scaler.
// in_ch carries one transaction per sensor event: func 0 reads a 32-bit frame,
// func 1 fetches a scaled sample (reading the frame first when no fresh sample
// is held). out_ch returns exactly one result transaction per input.
// Registers are to be written over the APB port (4 bytes apart) only while idle;
// the user must keep to this, as the block itself does not enforce it.
// A transaction needing no scaling goes from acceptance to output load; a
// scaling fetch runs accept, multiply, prepare, 35 divider steps, finish and
// output load, skipping the divider when the output count span is zero.
// in_ch.ready rises again in the cycle after the result is loaded, so one
// transaction is in flight at a time. A stalled receiver holds the result in
// the output register; the block can still take the next input meanwhile and
// parks its result until the output register frees up.
// Reset (synchronous, rst_n low) clears the stored counts and fresh flag,
// loads the register defaults and empties the output register.
module bridge_pressure_frame_scaler_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  bpfs_in_if.sink                             in_ch,
  bpfs_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpfs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bpfs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bpfs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import bpfs_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  dp_status_t status;

  bpfs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bpfs_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .cmd                   (cmd),
    .status                (status),
    .in_func               (in_ch.func),
    .in_read_ok            (in_ch.read_ok),
    .in_frame_word         (in_ch.frame_word),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_read_accepted     (out_ch.read_accepted),
    .out_sample_valid      (out_ch.sample_valid),
    .out_pressure_value    (out_ch.pressure_value),
    .out_temperature_centi (out_ch.temperature_centi)
  );

endmodule

### rtl/core/bpfs_checker.sv
module bpfs_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic                                    out_read_accepted,
  input logic                                    out_sample_valid,
  input logic signed [bpfs_pkg::OUT_PRESS_W-1:0] out_pressure_value,
  input logic signed [bpfs_pkg::OUT_TEMP_W-1:0]  out_temperature_centi
);
  import bpfs_pkg::*;

  // one transaction in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // no sample means zeroed payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |->
      out_pressure_value == '0 && out_temperature_centi == '0)
    else $error("payload not zero without a sample");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_valid |->
      out_temperature_centi >= -15'sd5000 && out_temperature_centi <= 15'sd15000)
    else $error("temperature out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure_value) &&
      $stable(out_read_accepted) && $stable(out_sample_valid))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bridge_pressure_frame_scaler_unit bpfs_checker u_bpfs_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_ch.valid),
  .in_ready              (in_ch.ready),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_read_accepted     (out_ch.read_accepted),
  .out_sample_valid      (out_ch.sample_valid),
  .out_pressure_value    (out_ch.pressure_value),
  .out_temperature_centi (out_ch.temperature_centi)
);
